@@ sv/jd2cd_pkg.sv @@
package jd2cd_pkg;

  // width of the day count
  localparam int DAY_BITS = 32;
  // tdata widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((DAY_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 5 + 4 + 24 + 1;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // quotient bits of day / 146097 (146097 > 2**17)
  localparam int GQ_BITS  = DAY_BITS - 17;
  localparam int CNT_BITS = $clog2(GQ_BITS);
  // astronomical year, two's complement, wide enough to test saturation
  localparam int YR_BITS  = (DAY_BITS - 6 > 26) ? DAY_BITS - 6 : 26;
  localparam int PC_BITS  = 5;

  localparam logic [DAY_BITS-1:0] GREG_START     = DAY_BITS'(2299239);
  localparam logic [DAY_BITS-1:0] JUL_LAST       = DAY_BITS'(2299160);
  // day count of 1 jan 1201 (gregorian), start of an aligned 400 year cycle
  localparam logic [DAY_BITS-1:0] GREG_BASE_DAYS = DAY_BITS'(2159717);
  // julian counting starts three years early so leap years close each group
  localparam logic [DAY_BITS-1:0] JUL_SHIFT      = DAY_BITS'(1095);
  localparam logic [DAY_BITS-1:0] JUL_SHIFT_GAP  = DAY_BITS'(1105);
  localparam logic [YR_BITS-1:0]  GREG_BASE_YEAR = YR_BITS'(1201);
  localparam logic [YR_BITS-1:0]  JUL_BASE_YEAR  = YR_BITS'(0) - YR_BITS'(4715);
  localparam logic [YR_BITS-1:0]  YEAR_MAX       = YR_BITS'(24'hFFFFFF);

  typedef enum logic [2:0] {
    OP_ORIGIN,
    OP_SETCNT,
    OP_DIVBIT,
    OP_SUB1,
    OP_MONTH,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    KSEL_GCYC,
    KSEL_JCENT,
    KSEL_GROUP,
    KSEL_CENT,
    KSEL_YEAR
  } ksel_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_JUMP,
    COND_GREG
  } cond_t;

  typedef struct packed {
    op_t                 op;
    ksel_t               sel;
    logic [CNT_BITS-1:0] imm;
    cond_t               cond;
    logic [PC_BITS-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic                load;
    logic                run;
    op_t                 op;
    ksel_t               sel;
    logic [CNT_BITS-1:0] imm;
  } dp_ctrl_t;

  typedef struct packed {
    logic greg;
    logic cnt_zero;
    logic month_take;
  } dp_stat_t;

  typedef struct packed {
    logic        before_common_era;
    logic [23:0] year_number;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
  } date_t;

  localparam logic [PC_BITS-1:0] PC_GREG  = PC_BITS'(8);
  localparam logic [PC_BITS-1:0] PC_MONTH = PC_BITS'(18);

  function automatic logic [DAY_BITS-1:0] span_days(ksel_t sel);
    case (sel)
      KSEL_GCYC:  return DAY_BITS'(146097);
      KSEL_JCENT: return DAY_BITS'(36525);
      KSEL_GROUP: return DAY_BITS'(1461);
      KSEL_CENT:  return DAY_BITS'(36524);
      KSEL_YEAR:  return DAY_BITS'(365);
      default:    return DAY_BITS'(365);
    endcase
  endfunction

  function automatic logic [YR_BITS-1:0] span_years(ksel_t sel);
    case (sel)
      KSEL_GCYC:  return YR_BITS'(400);
      KSEL_JCENT: return YR_BITS'(100);
      KSEL_GROUP: return YR_BITS'(4);
      KSEL_CENT:  return YR_BITS'(100);
      KSEL_YEAR:  return YR_BITS'(1);
      default:    return YR_BITS'(1);
    endcase
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:    return leap ? 5'd29 : 5'd28;
      default: return 5'd31;
    endcase
  endfunction

  function automatic uword_t uw(op_t op, ksel_t sel, int imm, cond_t cond,
                                logic [PC_BITS-1:0] target);
    uword_t w;
    w.op     = op;
    w.sel    = sel;
    w.imm    = CNT_BITS'(imm);
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // control program
  function automatic uword_t ucode_rom(logic [PC_BITS-1:0] pc);
    case (pc)
      // common entry: pick calendar, set origin
      5'd0:  return uw(OP_ORIGIN, KSEL_YEAR,  0, COND_GREG, PC_GREG);
      // julian: centuries, four year groups, years
      5'd1:  return uw(OP_SETCNT, KSEL_JCENT, 5, COND_NEXT, '0);
      5'd2:  return uw(OP_DIVBIT, KSEL_JCENT, 0, COND_NEXT, '0);
      5'd3:  return uw(OP_SETCNT, KSEL_GROUP, 4, COND_NEXT, '0);
      5'd4:  return uw(OP_DIVBIT, KSEL_GROUP, 0, COND_NEXT, '0);
      5'd5:  return uw(OP_SUB1,   KSEL_YEAR,  0, COND_NEXT, '0);
      5'd6:  return uw(OP_SUB1,   KSEL_YEAR,  0, COND_NEXT, '0);
      5'd7:  return uw(OP_SUB1,   KSEL_YEAR,  0, COND_JUMP, PC_MONTH);
      // gregorian: 400 year cycles, centuries, groups, years
      5'd8:  return uw(OP_SETCNT, KSEL_GCYC, GQ_BITS - 1, COND_NEXT, '0);
      5'd9:  return uw(OP_DIVBIT, KSEL_GCYC,  0, COND_NEXT, '0);
      5'd10: return uw(OP_SUB1,   KSEL_CENT,  0, COND_NEXT, '0);
      5'd11: return uw(OP_SUB1,   KSEL_CENT,  0, COND_NEXT, '0);
      5'd12: return uw(OP_SUB1,   KSEL_CENT,  0, COND_NEXT, '0);
      5'd13: return uw(OP_SETCNT, KSEL_GROUP, 4, COND_NEXT, '0);
      5'd14: return uw(OP_DIVBIT, KSEL_GROUP, 0, COND_NEXT, '0);
      5'd15: return uw(OP_SUB1,   KSEL_YEAR,  0, COND_NEXT, '0);
      5'd16: return uw(OP_SUB1,   KSEL_YEAR,  0, COND_NEXT, '0);
      5'd17: return uw(OP_SUB1,   KSEL_YEAR,  0, COND_NEXT, '0);
      // months, then result
      5'd18: return uw(OP_MONTH,  KSEL_YEAR,  0, COND_NEXT, '0);
      default: return uw(OP_DONE, KSEL_YEAR,  0, COND_NEXT, '0);
    endcase
  endfunction

endpackage

@@ sv/jd2cd_dpath.sv @@
module jd2cd_dpath (
  input  logic                             clk,
  input  jd2cd_pkg::dp_ctrl_t              ctrl,
  input  logic [jd2cd_pkg::DAY_BITS-1:0]   day_in,
  output jd2cd_pkg::dp_stat_t              stat,
  output jd2cd_pkg::date_t                 date
);
  import jd2cd_pkg::*;

  logic [DAY_BITS-1:0] raw;
  logic [DAY_BITS-1:0] rem, rem_next;
  logic [YR_BITS-1:0]  year, year_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic [1:0]          cent, cent_next;
  logic [4:0]          grp, grp_next;
  logic [1:0]          yr, yr_next;
  logic [3:0]          month, month_next;

  logic                greg;
  logic                leap;
  logic [DAY_BITS-1:0] span_sh;
  logic [YR_BITS-1:0]  yinc_sh;
  logic                fits;
  logic [4:0]          mlen;
  logic                month_take;
  logic                year_le0;
  logic [YR_BITS-1:0]  year_mag;

  assign greg = (raw >= GREG_START);
  // year closes a four year group; gregorian centuries leap only every 400
  assign leap = (yr == 2'd3) && !(greg && grp == 5'd24 && cent != 2'd3);

  assign span_sh = span_days(ctrl.sel) << cnt;
  assign yinc_sh = span_years(ctrl.sel) << cnt;
  assign fits    = (rem >= ((ctrl.op == OP_DIVBIT) ? span_sh : span_days(ctrl.sel)));

  assign mlen       = month_days(month, leap);
  assign month_take = (month != 4'd12) && (rem >= DAY_BITS'(mlen));

  always_comb begin
    rem_next   = rem;
    year_next  = year;
    cnt_next   = cnt;
    cent_next  = cent;
    grp_next   = grp;
    yr_next    = yr;
    month_next = month;
    if (ctrl.run) begin
      case (ctrl.op)
        OP_ORIGIN: begin
          if (greg) begin
            rem_next  = raw - GREG_BASE_DAYS;
            year_next = GREG_BASE_YEAR;
          end else begin
            rem_next  = raw + ((raw > JUL_LAST) ? JUL_SHIFT_GAP : JUL_SHIFT);
            year_next = JUL_BASE_YEAR;
          end
          cent_next  = '0;
          grp_next   = '0;
          yr_next    = '0;
          month_next = 4'd1;
        end
        OP_SETCNT: cnt_next = ctrl.imm;
        OP_DIVBIT: begin
          if (fits) begin
            rem_next  = rem - span_sh;
            year_next = year + yinc_sh;
            if (ctrl.sel == KSEL_GROUP) begin
              grp_next[cnt[2:0]] = 1'b1;
            end
          end
          if (cnt != '0) begin
            cnt_next = cnt - CNT_BITS'(1);
          end
        end
        OP_SUB1: begin
          if (fits) begin
            rem_next  = rem - span_days(ctrl.sel);
            year_next = year + span_years(ctrl.sel);
            if (ctrl.sel == KSEL_CENT) begin
              cent_next = cent + 2'd1;
            end else begin
              yr_next = yr + 2'd1;
            end
          end
        end
        OP_MONTH: begin
          if (month_take) begin
            rem_next   = rem - DAY_BITS'(mlen);
            month_next = month + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      raw <= day_in;
    end
    rem   <= rem_next;
    year  <= year_next;
    cnt   <= cnt_next;
    cent  <= cent_next;
    grp   <= grp_next;
    yr    <= yr_next;
    month <= month_next;
  end

  assign stat.greg       = greg;
  assign stat.cnt_zero   = (cnt == '0);
  assign stat.month_take = month_take;

  // astronomical year 0 is 1 bc
  assign year_le0 = year[YR_BITS-1] || (year == '0);
  assign year_mag = year_le0 ? (YR_BITS'(1) - year) : year;

  always_comb begin
    if (greg && !year[YR_BITS-1] && year > YEAR_MAX) begin
      date.day_of_month      = 5'd31;
      date.month_number      = 4'd12;
      date.year_number       = 24'hFFFFFF;
      date.before_common_era = 1'b0;
    end else begin
      date.day_of_month      = rem[4:0] + 5'd1;
      date.month_number      = month;
      date.year_number       = year_mag[23:0];
      date.before_common_era = year_le0;
    end
  end

endmodule

@@ sv/julian_day_to_calendar_date.sv @@
// julian day number to calendar date
//
// input channel s_*: one transaction carries a day count since 1 january
// 4713 bc (day 0). output channel m_*: one transaction per input, carrying
// day of month, month, year magnitude and a bc flag.
//
// one item is converted at a time by a small control program in a rom that
// steers a shared subtract-and-count datapath: 400 year cycles and julian
// centuries are peeled off one quotient bit per cycle, then centuries,
// four year groups, single years and months. gregorian dates take the
// longest, their quotient of 400 year cycles being the widest. the next
// item is taken in the cycle after the result is written at the earliest;
// a new item is never taken before the last one is through.
// s_tready is high whenever no conversion runs, so a new item is taken
// while a finished result still waits in the output register; if the
// receiver stalls, the sequencer holds at its last step until the output
// register frees up. the era flag travels in tdata with the date.
// reset (rst, synchronous) drops m_tvalid, clears busy and returns the
// sequencer to its entry step; no calendar state survives between items.
module julian_day_to_calendar_date (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [31:0] day_number
  input  logic [jd2cd_pkg::IN_DATA_BITS-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [4:0] day_of_month, [8:5] month_number, [32:9] year_number,
  // [33] before_common_era, upper bits zero
  output logic [jd2cd_pkg::OUT_DATA_BITS-1:0]   m_tdata
);
  import jd2cd_pkg::*;

  logic               busy, busy_next;
  logic [PC_BITS-1:0] pc, pc_next;
  logic               out_valid, out_valid_next;
  date_t              out_date;

  uword_t   word;
  dp_ctrl_t ctrl;
  dp_stat_t stat;
  date_t    date;
  logic     in_xfer;
  logic     out_free;
  logic     finish;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign word     = ucode_rom(pc);
  // last step retires only once the output register can take the result
  assign finish   = busy && (word.op == OP_DONE) && out_free;

  assign ctrl.load = in_xfer;
  assign ctrl.run  = busy;
  assign ctrl.op   = word.op;
  assign ctrl.sel  = word.sel;
  assign ctrl.imm  = word.imm;

  jd2cd_dpath u_dpath (
    .clk    (clk),
    .ctrl   (ctrl),
    .day_in (s_tdata[DAY_BITS-1:0]),
    .stat   (stat),
    .date   (date)
  );

  // sequencer: loops stay on their step, conditional jumps from the word
  always_comb begin
    pc_next        = pc;
    busy_next      = busy;
    out_valid_next = out_valid && !m_tready;
    if (!busy) begin
      if (in_xfer) begin
        busy_next = 1'b1;
        pc_next   = '0;
      end
    end else begin
      case (word.op)
        OP_DIVBIT: begin
          if (stat.cnt_zero) begin
            pc_next = pc + PC_BITS'(1);
          end
        end
        OP_MONTH: begin
          if (!stat.month_take) begin
            pc_next = pc + PC_BITS'(1);
          end
        end
        OP_DONE: begin
          if (finish) begin
            busy_next      = 1'b0;
            pc_next        = '0;
            out_valid_next = 1'b1;
          end
        end
        default: begin
          case (word.cond)
            COND_JUMP: pc_next = word.target;
            COND_GREG: pc_next = stat.greg ? word.target : pc + PC_BITS'(1);
            default:   pc_next = pc + PC_BITS'(1);
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_date <= date;
    end
  end

  assign s_tready = !busy;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}}, out_date};

endmodule

@@ dv/calendar_date_checker.sv @@
module calendar_date_checker
  import jd2cd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_DATA_BITS-1:0] m_tdata,
  output int                       mismatch_count,
  output int                       outstanding,
  output int                       dates_checked,
  output int                       gregorian_days
);

  localparam longint unsigned GREG_CYCLE_DAYS  = 146097;
  localparam longint unsigned JUL_CENTURY_DAYS = 36525;
  localparam longint unsigned FIRST_GREG_YEAR  = 1583;
  localparam longint unsigned BC_OFFSET        = 4712;
  localparam longint unsigned REFORM_GAP       = 10;
  localparam longint unsigned DATE_YEAR_MAX    = 24'hFFFFFF;
  localparam int unsigned MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [DAY_BITS-1:0] day;
    date_t               date;
  } dated_day_t;

  dated_day_t due_dates [$];
  int         errors  = 0;
  int         checked = 0;

  assign mismatch_count = errors;
  assign dates_checked  = checked;

  function automatic bit gregorian_leap(longint unsigned yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  // day and month from a zero based day of the year
  function automatic date_t place_in_year(longint unsigned doy, bit leap);
    date_t           d;
    int unsigned     m;
    longint unsigned len;
    bit              found;
    d     = '0;
    m     = 1;
    found = 1'b0;
    while (m < 12 && !found) begin
      len = MONTH_LEN[m];
      if (m == 2 && leap) len = 29;
      if (doy < len) begin
        found = 1'b1;
      end else begin
        doy -= len;
        m++;
      end
    end
    d.day_of_month = 5'(doy + 1);
    d.month_number = 4'(m);
    return d;
  endfunction

  function automatic date_t calendar_date_of(logic [DAY_BITS-1:0] day);
    date_t           d;
    longint unsigned rem;
    longint unsigned yr;
    longint unsigned ylen;
    bit              done;
    done = 1'b0;
    if (day >= GREG_START) begin
      rem = 64'(day) - 64'(GREG_START);
      yr  = FIRST_GREG_YEAR + 400 * (rem / GREG_CYCLE_DAYS);
      rem = rem % GREG_CYCLE_DAYS;
      while (!done) begin
        ylen = gregorian_leap(yr) ? 366 : 365;
        if (rem < ylen) begin
          done = 1'b1;
        end else begin
          rem -= ylen;
          yr++;
        end
      end
      if (yr > DATE_YEAR_MAX) begin
        d.day_of_month      = 5'd31;
        d.month_number      = 4'd12;
        d.year_number       = 24'hFFFFFF;
        d.before_common_era = 1'b0;
      end else begin
        d                   = place_in_year(rem, gregorian_leap(yr));
        d.year_number       = 24'(yr);
        d.before_common_era = 1'b0;
      end
    end else begin
      // yr counts julian years from 4713 bc, which is year zero here
      rem = 64'(day);
      if (day > JUL_LAST) rem += REFORM_GAP;
      yr  = 100 * (rem / JUL_CENTURY_DAYS);
      rem = rem % JUL_CENTURY_DAYS;
      while (!done) begin
        ylen = (yr % 4 == 0) ? 366 : 365;
        if (rem < ylen) begin
          done = 1'b1;
        end else begin
          rem -= ylen;
          yr++;
        end
      end
      d = place_in_year(rem, yr % 4 == 0);
      if (yr <= BC_OFFSET) begin
        d.year_number       = 24'(BC_OFFSET + 1 - yr);
        d.before_common_era = 1'b1;
      end else begin
        d.year_number       = 24'(yr - BC_OFFSET);
        d.before_common_era = 1'b0;
      end
    end
    return d;
  endfunction

  always @(posedge clk) begin : track
    dated_day_t entry;
    date_t      got;
    logic       pad_bad;
    if (rst) begin
      due_dates.delete();
      outstanding    <= 0;
      gregorian_days <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        entry.day  = s_tdata[DAY_BITS-1:0];
        entry.date = calendar_date_of(entry.day);
        due_dates.push_back(entry);
        if (entry.day >= GREG_START) gregorian_days <= gregorian_days + 1;
      end
      if (m_tvalid && m_tready) begin
        got     = date_t'(m_tdata[OUT_FIELD_BITS-1:0]);
        pad_bad = (m_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS] != '0);
        if (due_dates.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected date transaction, nothing pending: tdata %h", m_tdata);
        end else begin
          entry = due_dates.pop_front();
          checked++;
          if (got.day_of_month != entry.date.day_of_month ||
              got.month_number != entry.date.month_number ||
              got.year_number != entry.date.year_number ||
              got.before_common_era != entry.date.before_common_era || pad_bad) begin
            errors++;
            if (errors <= 10)
              $display("day %0d: expected %0d/%0d/%0d bc=%0b, got %0d/%0d/%0d bc=%0b pad=%h",
                       entry.day, entry.date.day_of_month, entry.date.month_number,
                       entry.date.year_number, entry.date.before_common_era,
                       got.day_of_month, got.month_number, got.year_number,
                       got.before_common_era, m_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS]);
          end
        end
      end
      outstanding <= due_dates.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
module testbench;
  import jd2cd_pkg::*;

  // receiver hold-off long enough to back up the sequencer and the input
  localparam int LONG_HOLD  = 400;
  // results taken before the long hold-off starts
  localparam int HOLD_AFTER = 200;
  localparam int RANDOM_DAYS = 1250;
  // allow several times the slowest run
  localparam int TIMEOUT = 5000000;

  // boundaries of both calendars, the reform gap, all-ones/all-zeros and alternating words
  localparam logic [DAY_BITS-1:0] EDGE_DAYS [24] = '{
    32'd0,          // first day of the count
    32'd58,         // 28 february, 4713 bc is a leap year
    32'd59,
    32'd365,        // last day of the first year
    32'd366,
    32'd1721423,    // last day of 1 bc, itself a leap year
    32'd1721424,    // first day of ad 1
    32'd2299159,
    32'd2299160,    // last julian day before the skipped days
    32'd2299161,    // first day after the gap
    32'd2299238,    // last day of 1582
    32'd2299239,    // first day under the gregorian rule
    32'd2415079,    // 1900 is not a leap year
    32'd2415080,
    32'd2451545,    // 2000 is a leap year
    32'd2451604,
    32'd2488128,    // 2100 is not a leap year
    32'd2488129,
    32'h7FFFFFFF,
    32'h80000000,
    32'h55555555,
    32'hAAAAAAAA,
    32'hFFFFFFFE,
    32'hFFFFFFFF    // widest input, year far beyond the present
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  int mismatch_count;
  int outstanding;
  int dates_checked;
  int gregorian_days;
  bit sender_burst = 1'b0;
  int days_sent = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  julian_day_to_calendar_date dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  calendar_date_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .dates_checked  (dates_checked),
    .gregorian_days (gregorian_days)
  );

  // offer one day count and wait for its transaction; valid stays high
  // across back-to-back items so it is never dropped and raised in one step
  task automatic offer_day(input logic [DAY_BITS-1:0] day);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_BITS'(day);
    do @(posedge clk); while (!s_tready);
    days_sent++;
  endtask

  // stop sending until every converted date is back
  task automatic drain_dates();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly julian and near-present gregorian days, some around the reform,
  // the rest over the whole 32-bit range
  function automatic logic [DAY_BITS-1:0] pick_day();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 7)
      return DAY_BITS'($urandom_range(0, 2299238));
    else if (r < 9)
      return DAY_BITS'($urandom_range(2299100, 2299300));
    else if (r < 15)
      return DAY_BITS'($urandom_range(2299239, 2700000));
    else
      return DAY_BITS'($urandom());
  endfunction

  // receiver: random stalls, stretches of full rate, one long hold-off
  initial begin : sink
    int unsigned stall;
    int          taken;
    bit          burst;
    taken = 0;
    burst = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, 10);
      if (taken == HOLD_AFTER) stall = LONG_HOLD;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // sender and verdict
  initial begin : source
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed boundary days
    foreach (EDGE_DAYS[i]) offer_day(EDGE_DAYS[i]);
    drain_dates();

    // random days, bursts now and then, one full drain midway
    for (int i = 0; i < RANDOM_DAYS; i++) begin
      if (i % 64 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_DAYS / 2) drain_dates();
      offer_day(pick_day());
    end
    s_tvalid <= 1'b0;

    // wait out the remaining conversions, then a margin past the latency
    do @(posedge clk); while (outstanding != 0);
    repeat (60) @(posedge clk);

    $display("checked %0d dates from %0d day counts, %0d of them gregorian",
             dates_checked, days_sent, gregorian_days);
    $display("included a %0d cycle output hold-off and a full drain pause", LONG_HOLD);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("[julian_day_to_calendar_date] OK");
    end else begin
      $display("[julian_day_to_calendar_date] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("[julian_day_to_calendar_date] ERROR");
    $finish;
  end

endmodule
